// ===== design/rna_pkg.sv =====
// package: command codes, status codes and widths for the rational number alu
`default_nettype none
package rna_pkg;
    localparam int INT_WIDTH_DEF = 32;
    localparam int CMD_W = 5;
    localparam int NUM_W = 32;
    localparam int DEN_W = 31;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD   = 5'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 5'd1;
    localparam logic [CMD_W-1:0] CMD_MUL   = 5'd2;
    localparam logic [CMD_W-1:0] CMD_DIV   = 5'd3;
    localparam logic [CMD_W-1:0] CMD_MOD   = 5'd4;
    localparam logic [CMD_W-1:0] CMD_NEG   = 5'd5;
    localparam logic [CMD_W-1:0] CMD_GCD   = 5'd6;
    localparam logic [CMD_W-1:0] CMD_TRUNC = 5'd7;
    localparam logic [CMD_W-1:0] CMD_AND   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_OR    = 5'd9;
    localparam logic [CMD_W-1:0] CMD_XOR   = 5'd10;
    localparam logic [CMD_W-1:0] CMD_NOT   = 5'd11;
    localparam logic [CMD_W-1:0] CMD_SHIFT = 5'd12;
    localparam logic [CMD_W-1:0] CMD_EQ    = 5'd13;
    localparam logic [CMD_W-1:0] CMD_LT    = 5'd14;
    localparam logic [CMD_W-1:0] CMD_LE    = 5'd15;
    localparam logic [CMD_W-1:0] CMD_GT    = 5'd16;
    localparam logic [CMD_W-1:0] CMD_GE    = 5'd17;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_TYPE = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIVZ = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // register operands
        OP_MUL1,     // tn1 = an*bd (an*bn for mul)
        OP_MUL2,     // tn2 = bn*ad
        OP_MUL3,     // td (or divisor) product
        OP_PREP,     // form raw num/den or integer result
        OP_DIVSTART, // start divider on x / y
        OP_DIVSTEP,  // one quotient bit
        OP_GCDNEXT,  // end of the trunc / mod divide: route quotient or remainder
        OP_RED_N,    // start n / g
        OP_RED_D,    // latch n quotient, start d / g
        OP_FINISH    // sign fix and output
    } t_op;

    typedef struct packed {
        t_op  op;
        logic use_rem;   // set in the reduce divides: leave x and y alone when the divide ends
    } t_ctl;

    typedef struct packed {
        logic div_done;
        logic y_zero;     // current euclid divisor is zero
        logic den_zero;   // raw denominator is zero
        logic need_div;   // prep decided the command needs a division path
        logic need_gcd;   // integer gcd command
        logic direct;     // result ready for finish, no further divide
    } t_stat;
endpackage
`default_nettype wire

// ===== design/rational_number_alu.sv =====
// top level of the rational number alu: controller plus datapath
//
// usage:
//   drive i_command and the two operands (numerator, denominator) and raise
//   start while busy is low; the word is taken at that clock edge.
//   one result word appears for one cycle on o_result_* with o_done high.
//   the receiver cannot hold off a result, so it must capture on o_done.
// steps per word, with W = INT_WIDTH and k euclid steps:
//   logic ops, shifts, compares and errors found before any divide: no divide
//   trunc: one divide; gcd: k euclid steps
//   add/sub/mul/div: k euclid steps, then two reduce divides; mod first adds a remainder divide
//   each euclid step is one W-bit restoring divide; k reaches about 1.5*W
// throughput: one word at a time, busy stays high until the result is out
// reset:
//   i_rst_n low at a clock edge returns the controller to idle, busy low.
//   no state is kept between words.
`default_nettype none
module rational_number_alu #(
    parameter int INT_WIDTH = rna_pkg::INT_WIDTH_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire [rna_pkg::CMD_W-1:0]    i_command,
    input  wire [rna_pkg::NUM_W-1:0]    i_a_num,
    input  wire [rna_pkg::DEN_W-1:0]    i_a_den,
    input  wire [rna_pkg::NUM_W-1:0]    i_b_num,
    input  wire [rna_pkg::DEN_W-1:0]    i_b_den,
    output logic                        o_done,
    output logic [rna_pkg::NUM_W-1:0]   o_result_num,
    output logic [rna_pkg::DEN_W-1:0]   o_result_den,
    output logic                        o_compare_true,
    output logic [rna_pkg::STAT_W-1:0]  o_status
);
    import rna_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    // controller: sequencing of multiply, euclid and reduce steps
    rna_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // datapath: operand registers, multiplier, divider, output register
    rna_dp #(.INT_WIDTH(INT_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_command      (i_command),
        .i_a_num        (i_a_num),
        .i_a_den        (i_a_den),
        .i_b_num        (i_b_num),
        .i_b_den        (i_b_den),
        .o_stat         (stat),
        .o_valid        (o_done),
        .o_result_num   (o_result_num),
        .o_result_den   (o_result_den),
        .o_compare_true (o_compare_true),
        .o_status       (o_status)
    );
endmodule
`default_nettype wire

// ===== design/rna_ctrl.sv =====
// controller state machine sequencing the rational alu datapath
`default_nettype none
module rna_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  rna_pkg::t_stat i_stat,
    output rna_pkg::t_ctl  o_ctl,
    output logic           o_busy
);
    import rna_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M1    = 4'd1;
    localparam logic [3:0] S_M2    = 4'd2;
    localparam logic [3:0] S_M3    = 4'd3;
    localparam logic [3:0] S_PREP  = 4'd4;
    localparam logic [3:0] S_DEC   = 4'd5;
    localparam logic [3:0] S_G     = 4'd6;  // euclid: test divisor
    localparam logic [3:0] S_GDIV  = 4'd7;
    localparam logic [3:0] S_RN    = 4'd8;
    localparam logic [3:0] S_RNDIV = 4'd9;
    localparam logic [3:0] S_RD    = 4'd10;
    localparam logic [3:0] S_RDDIV = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;
    localparam logic [3:0] S_TDIV  = 4'd13; // trunc / mod: route the result of the single divide
    localparam logic [3:0] S_TWAIT = 4'd14;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ctl.op      = OP_NONE;
        o_ctl.use_rem = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.op = OP_LOAD;
                    n_state  = S_M1;
                end
            end
            S_M1: begin o_ctl.op = OP_MUL1; n_state = S_M2; end
            S_M2: begin o_ctl.op = OP_MUL2; n_state = S_M3; end
            S_M3: begin o_ctl.op = OP_MUL3; n_state = S_PREP; end
            S_PREP: begin o_ctl.op = OP_PREP; n_state = S_DEC; end
            S_DEC: begin
                // direct covers logic ops, shifts, compares, errors and a finished trunc
                if (i_stat.direct) begin
                    o_ctl.op = OP_FINISH;
                    n_state  = S_IDLE;
                end else if (i_stat.need_gcd) begin
                    n_state = S_G;
                end else if (i_stat.need_div) begin
                    // trunc or mod numerator remainder: one divide, then reduce or finish
                    o_ctl.op = OP_DIVSTART;
                    n_state  = S_TWAIT;
                end else begin
                    n_state = S_G;
                end
            end
            S_TWAIT: begin
                o_ctl.op = OP_DIVSTEP;
                if (i_stat.div_done) n_state = S_TDIV;
            end
            S_TDIV: begin
                // datapath routes quotient or remainder; decide again once it is registered
                o_ctl.op      = OP_GCDNEXT;
                o_ctl.use_rem = 1'b1;
                n_state       = S_DEC;
            end
            S_G: begin
                if (i_stat.y_zero) begin
                    n_state = i_stat.need_gcd ? S_FIN : S_RN;
                end else begin
                    o_ctl.op = OP_DIVSTART;
                    n_state  = S_GDIV;
                end
            end
            S_GDIV: begin
                o_ctl.op = OP_DIVSTEP;
                if (i_stat.div_done) begin
                    n_state = S_G;
                end
            end
            S_RN: begin o_ctl.op = OP_RED_N; n_state = S_RNDIV; end
            S_RNDIV: begin
                // g stays in x for the denominator divide
                o_ctl.op      = OP_DIVSTEP;
                o_ctl.use_rem = 1'b1;
                if (i_stat.div_done) n_state = S_RD;
            end
            S_RD: begin o_ctl.op = OP_RED_D; n_state = S_RDDIV; end
            S_RDDIV: begin
                o_ctl.op      = OP_DIVSTEP;
                o_ctl.use_rem = 1'b1;
                if (i_stat.div_done) n_state = S_FIN;
            end
            S_FIN: begin o_ctl.op = OP_FINISH; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

// ===== design/rna_dp.sv =====
// datapath: multiplier, restoring divider, euclid registers and result formatting
`default_nettype none
module rna_dp #(
    parameter int INT_WIDTH = rna_pkg::INT_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  rna_pkg::t_ctl                i_ctl,
    input  wire [rna_pkg::CMD_W-1:0]     i_command,
    input  wire [rna_pkg::NUM_W-1:0]     i_a_num,
    input  wire [rna_pkg::DEN_W-1:0]     i_a_den,
    input  wire [rna_pkg::NUM_W-1:0]     i_b_num,
    input  wire [rna_pkg::DEN_W-1:0]     i_b_den,
    output rna_pkg::t_stat               o_stat,
    output logic                         o_valid,
    output logic [rna_pkg::NUM_W-1:0]    o_result_num,
    output logic [rna_pkg::DEN_W-1:0]    o_result_den,
    output logic                         o_compare_true,
    output logic [rna_pkg::STAT_W-1:0]   o_status
);
    import rna_pkg::*;

    localparam int W  = INT_WIDTH;
    localparam int CW = $clog2(W + 1);

    typedef logic [W-1:0] t_w;

    logic [CMD_W-1:0] r_cmd;
    t_w r_an, r_ad, r_bn, r_bd;
    logic r_aint, r_bint;
    t_w r_tn1, r_tn2, r_td;
    t_w r_x, r_y;         // euclid pair / divider operands
    t_w r_num, r_den;     // raw fraction
    t_w r_nq;             // reduced numerator
    t_w r_res;            // integer or final numerator
    t_w r_resd;
    logic r_cmpt;
    logic [STAT_W-1:0] r_st;
    logic r_direct, r_need_div, r_need_gcd;

    // divider
    t_w r_dq, r_drem, r_ddiv;
    logic r_dsq, r_dsr;    // quotient and remainder signs
    logic [CW-1:0] r_dcnt;
    logic r_dbusy;
    t_w r_dnum_mag;

    function automatic t_w f_mag(input t_w v);
        f_mag = v[W-1] ? (~v + t_w'(1)) : v;
    endfunction

    function automatic t_w f_ext_num(input logic [NUM_W-1:0] v);
        f_ext_num = t_w'($signed(v));
    endfunction

    function automatic t_w f_ext_den(input logic [DEN_W-1:0] v);
        logic [NUM_W-1:0] z;
        z = {1'b0, v};
        f_ext_den = t_w'($signed(z));
    endfunction

    // shared multiplier operands
    t_w m_a, m_b, m_p;
    always_comb begin
        m_a = r_an; m_b = r_bd;
        case (i_ctl.op)
            OP_MUL2: begin m_a = r_bn; m_b = r_ad; end
            OP_MUL3: begin
                m_a = r_ad;
                m_b = (r_cmd == CMD_DIV) ? r_bn : r_bd;
            end
            default: begin m_a = r_an; m_b = r_bd; end
        endcase
        // mul command numerator reuses tn1 slot through prep (an*bn computed in mul1)
        if (i_ctl.op == OP_MUL1 && r_cmd == CMD_MUL) m_b = r_bn;
        m_p = t_w'(m_a * m_b);
    end

    // shift
    t_w sh_res;
    t_w sh_k;
    always_comb begin
        sh_k = r_bn[W-1] ? (~r_bn + t_w'(1)) : r_bn;
        if (r_bn[W-1]) begin
            if (r_bn != {1'b1, {(W-1){1'b0}}} && sh_k < t_w'(W))
                sh_res = t_w'($signed(r_an) >>> sh_k[CW-1:0]);
            else
                sh_res = {W{r_an[W-1]}};
        end else begin
            if (sh_k < t_w'(W)) sh_res = r_an << sh_k[CW-1:0];
            else                sh_res = '0;
        end
    end

    // divider step
    t_w dv_trial_rem;
    logic [W:0] dv_sub;
    always_comb begin
        dv_trial_rem = {r_drem[W-2:0], r_dnum_mag[W-1]};
        dv_sub = {1'b0, dv_trial_rem} - {1'b0, r_ddiv};
    end
    // final signed quotient and remainder
    t_w dv_q, dv_r;
    always_comb begin
        dv_q = r_dsq ? (~r_dq + t_w'(1)) : r_dq;
        dv_r = r_dsr ? (~r_drem + t_w'(1)) : r_drem;
    end

    logic cmp_eq, cmp_lt, cmp_v;
    always_comb begin
        cmp_eq = (r_tn1 == r_tn2);
        cmp_lt = ($signed(r_tn1) < $signed(r_tn2));
        case (r_cmd)
            CMD_EQ:  cmp_v = cmp_eq;
            CMD_LT:  cmp_v = cmp_lt;
            CMD_LE:  cmp_v = cmp_eq | cmp_lt;
            CMD_GT:  cmp_v = ~(cmp_eq | cmp_lt);
            default: cmp_v = ~cmp_lt;
        endcase
    end

    t_w start_x, start_y;
    always_comb begin
        start_x = r_x; start_y = r_y;
        if (i_ctl.op == OP_RED_N) begin start_x = r_num; start_y = r_x; end
        if (i_ctl.op == OP_RED_D) begin start_x = r_den; start_y = r_x; end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_dbusy <= 1'b0;
        end else begin
            o_valid <= (i_ctl.op == OP_FINISH);
            if (i_ctl.op == OP_DIVSTART || i_ctl.op == OP_RED_N || i_ctl.op == OP_RED_D)
                r_dbusy <= 1'b1;
            else if (i_ctl.op == OP_DIVSTEP && r_dcnt == CW'(1))
                r_dbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_LOAD: begin
                r_cmd  <= i_command;
                r_an   <= f_ext_num(i_a_num);
                r_bn   <= f_ext_num(i_b_num);
                r_ad   <= f_ext_den(i_a_den);
                r_bd   <= f_ext_den(i_b_den);
                r_aint <= (i_a_den == DEN_W'(1));
                r_bint <= (i_b_den == DEN_W'(1));
            end
            OP_MUL1: r_tn1 <= m_p;
            OP_MUL2: r_tn2 <= m_p;
            OP_MUL3: r_td  <= m_p;
            OP_PREP: begin
                r_direct   <= 1'b1;
                r_need_div <= 1'b0;
                r_need_gcd <= 1'b0;
                r_st       <= ST_OK;
                r_cmpt     <= 1'b0;
                r_res      <= '0;
                r_resd     <= '0;
                r_x        <= '0;
                r_y        <= '0;
                if (r_cmd <= CMD_MOD) begin
                    r_direct <= 1'b0;
                    case (r_cmd)
                        CMD_ADD: r_num <= r_tn1 + r_tn2;
                        CMD_SUB: r_num <= r_tn1 - r_tn2;
                        default: r_num <= r_tn1;
                    endcase
                    r_den <= r_td;
                    if (r_cmd == CMD_ADD) r_x <= r_tn1 + r_tn2;
                    else if (r_cmd == CMD_SUB) r_x <= r_tn1 - r_tn2;
                    else r_x <= r_tn1;
                    r_y <= r_td;
                    if (r_cmd == CMD_MOD) begin
                        if (r_tn2 == '0) begin
                            r_direct <= 1'b1;
                            r_st     <= ST_DIVZ;
                        end else begin
                            r_need_div <= 1'b1;
                            r_y        <= r_tn2;
                        end
                    end else if (r_td == '0) begin
                        r_direct <= 1'b1;
                        r_st     <= ST_DIVZ;
                    end
                end else if (r_cmd <= CMD_SHIFT) begin
                    r_resd <= t_w'(1);
                    if (!r_aint || (r_cmd != CMD_NEG && r_cmd != CMD_NOT && !r_bint)) begin
                        r_st   <= ST_TYPE;
                        r_resd <= '0;
                    end else begin
                        case (r_cmd)
                            CMD_NEG: r_res <= ~r_an + t_w'(1);
                            CMD_GCD: begin
                                r_direct   <= 1'b0;
                                r_need_gcd <= 1'b1;
                                r_x        <= r_an;
                                r_y        <= r_bn;
                            end
                            CMD_TRUNC: begin
                                if (r_bn == '0) begin
                                    r_st   <= ST_DIVZ;
                                    r_resd <= '0;
                                end else begin
                                    r_direct   <= 1'b0;
                                    r_need_div <= 1'b1;
                                    r_x        <= r_an;
                                    r_y        <= r_bn;
                                end
                            end
                            CMD_AND: r_res <= r_an & r_bn;
                            CMD_OR:  r_res <= r_an | r_bn;
                            CMD_XOR: r_res <= r_an ^ r_bn;
                            CMD_NOT: r_res <= ~r_an;
                            default: r_res <= sh_res;
                        endcase
                    end
                end else if (r_cmd <= CMD_GE) begin
                    r_cmpt <= cmp_v;
                end
            end
            OP_DIVSTART, OP_RED_N, OP_RED_D: begin
                if (i_ctl.op == OP_RED_D) r_nq <= dv_q;
                r_dnum_mag <= f_mag(start_x);
                r_ddiv     <= f_mag(start_y);
                r_dsq      <= start_x[W-1] ^ start_y[W-1];
                r_dsr      <= start_x[W-1];
                r_dq       <= '0;
                r_drem     <= '0;
                r_dcnt     <= CW'(W);
            end
            OP_DIVSTEP: begin
                if (r_dbusy) begin
                    r_dnum_mag <= r_dnum_mag << 1;
                    r_dcnt     <= r_dcnt - CW'(1);
                    if (!dv_sub[W]) begin
                        r_drem <= dv_sub[W-1:0];
                        r_dq   <= {r_dq[W-2:0], 1'b1};
                    end else begin
                        r_drem <= dv_trial_rem;
                        r_dq   <= {r_dq[W-2:0], 1'b0};
                    end
                    // euclid update when the divide ends (not in reduce)
                    if (r_dcnt == CW'(1) && !i_ctl.use_rem) begin
                        r_x <= r_y;
                        r_y <= r_dsr ? ~(dv_sub[W] ? dv_trial_rem : dv_sub[W-1:0])
                                       + t_w'(1)
                                     : (dv_sub[W] ? dv_trial_rem : dv_sub[W-1:0]);
                    end
                end
            end
            OP_GCDNEXT: begin
                // end of the single trunc / mod divide
                r_need_div <= 1'b0;
                if (r_cmd == CMD_TRUNC) begin
                    r_res    <= dv_q;
                    r_direct <= 1'b1;
                end else begin
                    r_num <= dv_r;
                    r_x   <= dv_r;
                    r_y   <= r_td;
                    r_den <= r_td;
                    if (r_td == '0) begin
                        r_direct <= 1'b1;
                        r_st     <= ST_DIVZ;
                    end
                end
            end
            OP_FINISH: begin
                if (r_st != ST_OK) begin
                    o_result_num <= '0;
                    o_result_den <= '0;
                end else if (r_need_gcd) begin
                    o_result_num <= NUM_W'(f_mag(r_x));
                    o_result_den <= DEN_W'(1);
                end else if (r_cmd <= CMD_MOD && !r_direct) begin
                    if (dv_q[W-1]) begin
                        o_result_num <= NUM_W'(~r_nq + t_w'(1));
                        o_result_den <= DEN_W'(~dv_q + t_w'(1));
                    end else begin
                        o_result_num <= NUM_W'(r_nq);
                        o_result_den <= DEN_W'(dv_q);
                    end
                end else begin
                    o_result_num <= NUM_W'(r_res);
                    o_result_den <= DEN_W'(r_resd);
                end
                o_compare_true <= r_cmpt;
                o_status       <= r_st;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.div_done = r_dbusy && (r_dcnt == CW'(1));
        o_stat.y_zero   = (r_y == '0);
        o_stat.den_zero = (r_den == '0);
        o_stat.need_div = r_need_div;
        o_stat.need_gcd = r_need_gcd;
        o_stat.direct   = r_direct;
    end
endmodule
`default_nettype wire

// ===== design/rna_checker.sv =====
// port-level checker for the rational number alu, bound to the top level
`default_nettype none
module rna_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_done,
    input wire [1:0]  o_status,
    input wire [30:0] o_result_den,
    input wire        o_compare_true
);
    import rna_pkg::*;

    // a word taken makes the block busy next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("start not taken");
    // a result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
    // a result ends the busy period
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("done while busy");
    // errors carry a zero denominator and a false compare flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_result_den == 31'd0 && !o_compare_true)
        else $error("error result not cleared");
endmodule

bind rational_number_alu rna_checker u_rna_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_result_den   (o_result_den),
    .o_compare_true (o_compare_true)
);
`default_nettype wire
